// File: rtl/tlpd_pkg.sv
// Package for the two-level priority deque: word types, codes and defaults.
// No dependencies; used by tlpd_slot_ram and two_level_priority_deque.
`default_nettype none

package tlpd_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int KEY_W         = 8;

	// operation codes
	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_DEQ = 2'd1;
	localparam logic [1:0] MODE_CLR = 2'd2;

	// enqueue priorities
	localparam logic [1:0] PRIO_NORMAL = 2'd0;
	localparam logic [1:0] PRIO_URGENT = 2'd1;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_BADPRIO = 2'd3;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] in_key;
		logic [1:0]       in_priority;
	} req_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [KEY_W-1:0] out_key;
		logic             out_priority;
		logic             now_empty;
		logic             now_full;
	} rsp_word_t;

	// one stored slot: priority bit above the key
	typedef struct packed {
		logic             prio;
		logic [KEY_W-1:0] key;
	} slot_t;

endpackage

`default_nettype wire

// File: rtl/tlpd_slot_ram.sv
// Slot memory of the deque: one write port, one read port, registered read data.
// Depends on tlpd_pkg for the slot word type.
`default_nettype none

module tlpd_slot_ram #(
	parameter int DEPTH = tlpd_pkg::DEPTH_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire tlpd_pkg::slot_t            wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output tlpd_pkg::slot_t                 rd_data
);
	import tlpd_pkg::*;

	slot_t mem_q [DEPTH];
	slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/two_level_priority_deque.sv
// Top level of the two-level priority deque: pointers, count and result register.
// Depends on tlpd_pkg and tlpd_slot_ram.
`default_nettype none

//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------------------
//  req     | in        | req_valid, req_ready | mode, in_key, in_priority
//  rsp     | out       | rsp_valid, rsp_ready | status, out_key, out_priority,
//          |           |                      | now_empty, now_full
//
//  Enqueue, clear and no-op words may follow back to back while the rsp side takes
//  each result. A dequeue that returns an item goes through the registered slot
//  memory read first, and req_ready stays low during that read.
//  Reset (arst_n low) empties the deque at once; no clearing pass is needed, since
//  only written slots are ever read.
//  A stalled rsp holds its word in the result register; a new req word is taken
//  in the same cycle that the waiting result is taken.

module two_level_priority_deque #(
	parameter int DEPTH = tlpd_pkg::DEPTH_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire tlpd_pkg::req_word_t  req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output tlpd_pkg::rsp_word_t       rsp
);
	import tlpd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// pointer and occupancy state
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	// next-state values and memory controls
	logic [AW-1:0] head_d, tail_d, head_inc, head_dec, tail_inc;
	logic [CW-1:0] count_d;
	logic          wr_req, rd_req, is_full, is_empty, acc, deq_go;
	logic [AW-1:0] wr_addr;
	slot_t         wr_data, rd_data;
	rsp_word_t     res;

	// dequeue in flight: read issued, data lands next cycle
	logic          rd_pend_s1;
	logic          pend_empty_s1, pend_full_s1;

	logic          rsp_valid_q;
	rsp_word_t     rsp_q;

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// wrap the ring pointers at DEPTH, which need not be a power of two
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign tail_inc = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);

	// take a new word only when no read is pending and the result slot frees up
	assign req_ready = !rd_pend_s1 && (!rsp_valid_q || rsp_ready);
	assign acc       = req_valid && req_ready;

	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		wr_req       = 1'b0;
		rd_req       = 1'b0;
		wr_addr      = tail_q;
		wr_data.prio = 1'b0;
		wr_data.key  = req.in_key;
		res          = '0;
		res.status   = ST_OK;
		case (req.mode)
			MODE_ENQ: begin
				if (is_full) begin
					// full is checked before priority
					res.status = ST_FULL;
				end else if (req.in_priority == PRIO_NORMAL) begin
					wr_req  = 1'b1;
					tail_d  = tail_inc;
					count_d = count_q + CW'(1);
				end else if (req.in_priority == PRIO_URGENT) begin
					// push in front of the head
					wr_req       = 1'b1;
					wr_addr      = head_dec;
					wr_data.prio = 1'b1;
					head_d       = head_dec;
					count_d      = count_q + CW'(1);
				end else begin
					res.status = ST_BADPRIO;
				end
			end
			MODE_DEQ: begin
				if (is_empty) begin
					res.status = ST_EMPTY;
				end else begin
					rd_req  = 1'b1;
					head_d  = head_inc;
					count_d = count_q - CW'(1);
				end
			end
			MODE_CLR: begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
			default: begin
				// no operation
			end
		endcase
		res.now_empty = (count_d == '0);
		res.now_full  = (count_d == CW'(DEPTH));
	end

	assign deq_go = acc && rd_req;

	tlpd_slot_ram #(
		.DEPTH (DEPTH)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (acc && wr_req),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (deq_go),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	// advance pointers and count on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rd_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
			rd_pend_s1 <= deq_go;
			if (rd_pend_s1 || (acc && !rd_req)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold flags for a dequeue until its slot data returns
	always_ff @(posedge clk) begin
		if (deq_go) begin
			pend_empty_s1 <= res.now_empty;
			pend_full_s1  <= res.now_full;
		end
	end

	// result register: load a dequeued slot, or a direct result on accept
	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			rsp_q.status       <= ST_OK;
			rsp_q.out_key      <= rd_data.key;
			rsp_q.out_priority <= rd_data.prio;
			rsp_q.now_empty    <= pend_empty_s1;
			rsp_q.now_full     <= pend_full_s1;
		end else if (acc && !rd_req) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the count never exceeds the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("deque count above DEPTH");

	// a partly filled ring never has head and tail on the same slot
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 && count_q != CW'(DEPTH)) |-> (head_q != tail_q))
		else $error("head and tail collide on a partly filled deque");

	// a pending read always turns into a result next cycle
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |=> rsp_valid)
		else $error("dequeue read did not produce a result");

	// no new word enters while a read is in flight
	a_read_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !req_ready)
		else $error("word accepted during pending read");

	// the result register is free whenever read data lands
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		deq_go |=> (!rsp_valid))
		else $error("result register busy when dequeue data arrives");

endmodule

`default_nettype wire

// File: tb/tb_two_level_priority_deque.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_level_priority_deque: random and directed words,
// a cycle-free predictor of the deque, and random stalls on both channels.
// Depends on tlpd_pkg and the two_level_priority_deque RTL.

module tb_two_level_priority_deque;

	import tlpd_pkg::*;

	localparam int DEPTH      = DEPTH_DEFAULT;
	localparam int HOLD_AT_A  = 330;	// accepted-word counts that start a long rsp hold
	localparam int HOLD_AT_B  = 880;
	localparam int HOLD_LEN   = 90;
	localparam int N_RANDOM   = 1425;

	// one pending req word with its idle gap and an optional drain-before-send flag
	typedef struct {
		req_word_t word;
		int        gap;
		bit        drain;
	} req_item_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	req_item_t req_backlog[$];
	rsp_word_t rsp_due[$];

	// predicted deque contents
	slot_t     q_slots[DEPTH];
	int        q_head = 0;
	int        q_tail = 0;
	int        q_count = 0;

	int        acc_count = 0;	// req words accepted, updated with NBA
	int        rsp_count = 0;	// rsp words taken, updated with NBA
	int        err_count = 0;
	int        n_words;

	// driver, receiver and long-hold bookkeeping
	bit        drv_took;
	bit        drv_free;
	bit        drv_armed = 1'b0;
	int        drv_gap = 0;
	int        rx_stall = 0;
	logic      rx_hold = 1'b0;
	int        hold_left = 0;
	int        hold_mark = -1;
	rsp_word_t want;

	two_level_priority_deque #(.DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Stretches of the run where neither side idles.
	function automatic bit in_burst(input int n);
		return (n % 250) >= 80 && (n % 250) < 160;
	endfunction

	// Advance the predicted deque by one req word and return the rsp word it yields.
	function automatic rsp_word_t deque_apply(input req_word_t w);
		rsp_word_t r;
		slot_t     e;
		r = '0;
		case (w.mode)
			MODE_ENQ: begin
				// full is checked ahead of the priority
				if (q_count == DEPTH) begin
					r.status = ST_FULL;
				end else if (w.in_priority == PRIO_NORMAL) begin
					q_slots[q_tail] = '{prio: 1'b0, key: w.in_key};
					q_tail = (q_tail == DEPTH - 1) ? 0 : q_tail + 1;
					q_count++;
				end else if (w.in_priority == PRIO_URGENT) begin
					q_head = (q_head == 0) ? DEPTH - 1 : q_head - 1;
					q_slots[q_head] = '{prio: 1'b1, key: w.in_key};
					q_count++;
				end else begin
					r.status = ST_BADPRIO;
				end
			end
			MODE_DEQ: begin
				if (q_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					e = q_slots[q_head];
					r.out_key = e.key;
					r.out_priority = e.prio;
					q_head = (q_head == DEPTH - 1) ? 0 : q_head + 1;
					q_count--;
				end
			end
			MODE_CLR: begin
				q_head = 0;
				q_tail = 0;
				q_count = 0;
			end
			default: ;	// no-op word
		endcase
		r.now_empty = (q_count == 0);
		r.now_full = (q_count == DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("[%0t] rsp word %0d: %s got %0d, expected %0d",
			$time, rsp_count, what, got, exp_val);
		err_count++;
	endtask

	task automatic queue_word(input logic [1:0] mode, input logic [7:0] key,
			input logic [1:0] prio, input bit drain);
		req_item_t it;
		it.word = '{mode: mode, in_key: key, in_priority: prio};
		it.gap = in_burst(req_backlog.size()) ? 0 : $urandom_range(0, 8);
		it.drain = drain;
		req_backlog.push_back(it);
	endtask

	// Driver: predict each accepted word, then offer the next after its gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			drv_armed = 1'b0;
			drv_gap = 0;
		end else begin
			drv_took = req_valid && req_ready;
			if (drv_took) begin
				rsp_due.push_back(deque_apply(req));
				acc_count <= acc_count + 1;
			end
			drv_free = !req_valid || drv_took;
			if (drv_free) begin
				if (!drv_armed && req_backlog.size() != 0) begin
					drv_armed = 1'b1;
					drv_gap = req_backlog[0].gap;
				end
				// a drain word waits until every rsp word owed so far has come back
				if (drv_armed && drv_gap == 0 && (!req_backlog[0].drain ||
						(!drv_took && acc_count == rsp_count))) begin
					req <= req_backlog[0].word;
					req_backlog.delete(0);
					req_valid <= 1'b1;
					drv_armed = 1'b0;
				end else begin
					req_valid <= 1'b0;
					if (drv_armed && drv_gap > 0)
						drv_gap--;
				end
			end
		end
	end

	// Long rsp hold: hold rsp_ready low for a stretch so the deque backs up into req.
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_hold <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_left == 0 && acc_count != hold_mark &&
					(acc_count == HOLD_AT_A || acc_count == HOLD_AT_B)) begin
				hold_left = HOLD_LEN;
				hold_mark = acc_count;
			end
			if (hold_left > 0)
				hold_left--;
			rx_hold <= (hold_left > 0);
		end
	end

	// Monitor: check each rsp word against the oldest prediction, then stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_count <= rsp_count + 1;
				if (rsp_due.size() == 0) begin
					report_mismatch("word with nothing due, status", rsp.status, -1);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.out_key !== want.out_key)
						report_mismatch("out_key", rsp.out_key, want.out_key);
					if (rsp.out_priority !== want.out_priority)
						report_mismatch("out_priority", rsp.out_priority, want.out_priority);
					if (rsp.now_empty !== want.now_empty)
						report_mismatch("now_empty", rsp.now_empty, want.now_empty);
					if (rsp.now_full !== want.now_full)
						report_mismatch("now_full", rsp.now_full, want.now_full);
				end
				rx_stall = in_burst(acc_count) ? 0 : $urandom_range(0, 8);
			end
			if (rx_hold) begin
				rsp_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int pick;
		int phase;
		logic [1:0] mode;
		logic [1:0] prio;

		// directed: empty dequeue, bad priority on an empty deque, both priorities,
		// urgent word dequeued first, no-op, fill to full, full beats bad priority, clear
		queue_word(MODE_DEQ, 8'hA5, PRIO_NORMAL, 1'b0);
		queue_word(MODE_ENQ, 8'h3C, 2'd3, 1'b0);
		queue_word(MODE_ENQ, 8'h00, PRIO_NORMAL, 1'b0);
		queue_word(MODE_ENQ, 8'hFF, PRIO_URGENT, 1'b0);
		queue_word(MODE_DEQ, 8'h00, 2'd3, 1'b0);
		queue_word(MODE_DEQ, 8'hFF, 2'd2, 1'b0);
		queue_word(2'd3, 8'h5A, PRIO_URGENT, 1'b0);
		for (int k = 0; k < DEPTH; k++)
			queue_word(MODE_ENQ, 8'($urandom_range(0, 255)),
				(k % 2) ? PRIO_URGENT : PRIO_NORMAL, 1'b0);
		queue_word(MODE_ENQ, 8'h81, PRIO_NORMAL, 1'b0);
		queue_word(MODE_ENQ, 8'h7E, 2'd2, 1'b0);
		queue_word(MODE_CLR, 8'h42, 2'd1, 1'b1);	// sender drains first
		queue_word(MODE_DEQ, 8'h18, PRIO_NORMAL, 1'b0);

		// random: phases that lean toward filling, draining or neither
		phase = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0)
				phase = $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			if (pick < ((phase == 0) ? 72 : (phase == 1) ? 25 : 48))
				mode = MODE_ENQ;
			else if (pick < 94)
				mode = MODE_DEQ;
			else if (pick < 97)
				mode = MODE_CLR;
			else
				mode = 2'd3;
			pick = $urandom_range(0, 99);
			prio = (pick < 55) ? PRIO_NORMAL : (pick < 90) ? PRIO_URGENT :
				(pick < 95) ? 2'd2 : 2'd3;
			queue_word(mode, 8'($urandom_range(0, 255)), prio, (i % 350) == 200);
		end
		n_words = req_backlog.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (acc_count != n_words || rsp_count != acc_count)
			@(posedge clk);
		// let any stray rsp word surface
		repeat (8) @(posedge clk);
		if (rsp_due.size() != 0)
			report_mismatch("predictions left over", rsp_due.size(), 0);

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/tlpd_pkg.sv
rtl/tlpd_slot_ram.sv
rtl/two_level_priority_deque.sv
tb/tb_two_level_priority_deque.sv
